// ===== hw/rtl/pvd_pkg.sv =====
package pvd_pkg;

    localparam int COORD_W   = 2;
    localparam int SIZE_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;

    // input command codes (carried on tuser)
    localparam logic CMD_MARK   = 1'b0;
    localparam logic CMD_COMMIT = 1'b1;

    // event kinds (carried on tuser)
    localparam logic EV_ENTER = 1'b0;
    localparam logic EV_EXIT  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [SIZE_W-1:0]  t_size;

    typedef struct packed {
        logic cur;
        logic pend;
    } t_page;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic   kind;
        t_coord x;
        t_coord y;
        t_coord z;
    } t_event;

endpackage

// ===== hw/rtl/pvd_cell.sv =====
module pvd_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pvd_pkg::t_cell_ctl i_ctl,
    input  logic              i_mark,
    input  pvd_pkg::t_page    i_next,
    output pvd_pkg::t_page    o_page
);

    pvd_pkg::t_page r_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
        end else if (i_ctl.clear) begin
            r_page <= '0;
        end else if (i_ctl.shift) begin
            r_page <= i_next;
        end else if (i_mark) begin
            r_page.pend <= 1'b1;
        end
    end

    assign o_page = r_page;

endmodule

// ===== hw/rtl/pvd_scan.sv =====
module pvd_scan #(
    parameter int MAX_X = 4,
    parameter int MAX_Y = 4,
    parameter int MAX_Z = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pvd_pkg::t_page  i_head,
    input  pvd_pkg::t_size  i_eff_x,
    input  pvd_pkg::t_size  i_eff_y,
    input  pvd_pkg::t_size  i_eff_z,
    input  logic            i_out_ready,
    output logic            o_idle,
    output logic            o_step,
    output logic            o_out_valid,
    output pvd_pkg::t_event o_out_event,
    output logic            o_out_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam pvd_pkg::t_coord LAST_X = pvd_pkg::COORD_W'(MAX_X - 1);
    localparam pvd_pkg::t_coord LAST_Y = pvd_pkg::COORD_W'(MAX_Y - 1);
    localparam pvd_pkg::t_coord LAST_Z = pvd_pkg::COORD_W'(MAX_Z - 1);

    logic [1:0]      r_state, n_state;
    pvd_pkg::t_coord r_x, n_x, r_y, n_y, r_z, n_z;
    logic            r_held_v, n_held_v;
    pvd_pkg::t_event r_held, n_held;
    logic            r_out_v, n_out_v;
    pvd_pkg::t_event r_out, n_out;
    logic            r_out_last, n_out_last;

    logic            in_range;
    logic            diff;
    logic            out_free;
    logic            step;
    logic            at_end;
    pvd_pkg::t_event head_ev;

    always_comb begin
        in_range = ({1'b0, r_x} < i_eff_x) && ({1'b0, r_y} < i_eff_y)
                && ({1'b0, r_z} < i_eff_z);
        diff     = (i_head.cur ^ i_head.pend) && in_range;
        out_free = !r_out_v || i_out_ready;
        // stall only when a new event needs the held slot and it cannot drain
        step     = (r_state == ST_SCAN) && !(diff && r_held_v && !out_free);
        at_end   = (r_x == LAST_X) && (r_y == LAST_Y) && (r_z == LAST_Z);

        head_ev.kind = i_head.pend ? pvd_pkg::EV_ENTER : pvd_pkg::EV_EXIT;
        head_ev.x    = r_x;
        head_ev.y    = r_y;
        head_ev.z    = r_z;

        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_held_v   = r_held_v;
        n_held     = r_held;
        n_out_v    = r_out_v && !i_out_ready;
        n_out      = r_out;
        n_out_last = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step) begin
                    if (diff) begin
                        if (r_held_v) begin
                            n_out_v    = 1'b1;
                            n_out      = r_held;
                            n_out_last = 1'b0;
                        end
                        n_held_v = 1'b1;
                        n_held   = head_ev;
                    end
                    // y innermost, then x, then z
                    if (r_y == LAST_Y) begin
                        n_y = '0;
                        if (r_x == LAST_X) begin
                            n_x = '0;
                            n_z = (r_z == LAST_Z) ? '0 : r_z + pvd_pkg::t_coord'(1);
                        end else begin
                            n_x = r_x + pvd_pkg::t_coord'(1);
                        end
                    end else begin
                        n_y = r_y + pvd_pkg::t_coord'(1);
                    end
                    if (at_end) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_held_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_held;
                    n_out_last = 1'b1;
                    n_held_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_x      <= '0;
            r_y      <= '0;
            r_z      <= '0;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
            r_held_v <= n_held_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_step      = step;
    assign o_out_valid = r_out_v;
    assign o_out_event = r_out;
    assign o_out_last  = r_out_last;

    a_idle_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_held_v)
        else $error("held event left over outside a commit");

    a_idle_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_out_v) |-> r_out_last)
        else $error("commit ended without flagging its final event");

    a_flush_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_x == '0 && r_y == '0 && r_z == '0))
        else $error("scan counters not wrapped at end of commit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !step) |=> ($stable(r_x) && $stable(r_y) && $stable(r_z)))
        else $error("scan advanced while stalled");

endmodule

// ===== hw/rtl/page_visibility_diff.sv =====
// Page visibility change detector over a MAX_X x MAX_Y x MAX_Z page grid. A mark
// transaction (tuser = 0) sets the pending flag of one page; marks beyond the
// configured size are dropped. A commit transaction (tuser = 1) rotates the ring of page
// cells once past the scan head, one page per cycle unless the output is held off by
// m_axis_tready; s_axis_tready is low from then until the scan and its final flush are
// done. Each changed page gives one event (tuser 0 = entered, 1 = exited), z outermost,
// then x, then y, with tlast on the final one; a commit with no change emits nothing.
// Writing any size register clears both maps.
module page_visibility_diff #(
    parameter int MAX_X = 4,
    parameter int MAX_Y = 4,
    parameter int MAX_Z = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [1:0] page_x, [3:2] page_y, [5:4] page_z, rest 0
    input  logic       s_axis_tuser,   // command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] event_x, [3:2] event_y, [5:4] event_z, rest 0
    output logic       m_axis_tuser,   // event_kind
    output logic       m_axis_tlast,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [2:0] i_cfg_data
);

    localparam int NUM_PAGES = MAX_X * MAX_Y * MAX_Z;
    localparam int SLOT_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    pvd_pkg::t_size r_size_x, r_size_y, r_size_z;
    pvd_pkg::t_size eff_x, eff_y, eff_z;

    pvd_pkg::t_page     page [NUM_PAGES];
    pvd_pkg::t_page     next [NUM_PAGES];
    logic               mark_hit [NUM_PAGES];
    pvd_pkg::t_cell_ctl cell_ctl;

    logic              in_accept;
    logic              cfg_hit;
    logic              mark_v;
    logic [SLOT_W-1:0] mark_slot;
    pvd_pkg::t_coord   in_x, in_y, in_z;
    logic              scan_idle;
    logic              scan_step;
    pvd_pkg::t_event   out_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= pvd_pkg::SIZE_RESET;
            r_size_y <= pvd_pkg::SIZE_RESET;
            r_size_z <= pvd_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pvd_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data;
                pvd_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data;
                pvd_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_hit = i_cfg_we && (i_cfg_idx == pvd_pkg::CFG_SIZE_X
                               || i_cfg_idx == pvd_pkg::CFG_SIZE_Y
                               || i_cfg_idx == pvd_pkg::CFG_SIZE_Z);

    assign eff_x = (r_size_x > pvd_pkg::SIZE_W'(MAX_X)) ? pvd_pkg::SIZE_W'(MAX_X) : r_size_x;
    assign eff_y = (r_size_y > pvd_pkg::SIZE_W'(MAX_Y)) ? pvd_pkg::SIZE_W'(MAX_Y) : r_size_y;
    assign eff_z = (r_size_z > pvd_pkg::SIZE_W'(MAX_Z)) ? pvd_pkg::SIZE_W'(MAX_Z) : r_size_z;

    assign s_axis_tready = scan_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_x          = s_axis_tdata[1:0];
    assign in_y          = s_axis_tdata[3:2];
    assign in_z          = s_axis_tdata[5:4];

    assign mark_v = in_accept && (s_axis_tuser == pvd_pkg::CMD_MARK)
                 && ({1'b0, in_x} < eff_x) && ({1'b0, in_y} < eff_y)
                 && ({1'b0, in_z} < eff_z);

    // ring position follows scan order: y fastest, then x, then z
    assign mark_slot = SLOT_W'(in_y) + SLOT_W'(MAX_Y)
                     * (SLOT_W'(in_x) + SLOT_W'(MAX_X) * SLOT_W'(in_z));

    assign cell_ctl.shift = scan_step;
    assign cell_ctl.clear = cfg_hit;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_PAGES; gi++) begin : g_cell
            if (gi == NUM_PAGES - 1) begin : g_tail
                // page leaving the head comes back round already committed
                assign next[gi] = '{cur: page[0].pend, pend: 1'b0};
            end else begin : g_body
                assign next[gi] = page[gi + 1];
            end
            assign mark_hit[gi] = mark_v && (mark_slot == SLOT_W'(gi));

            pvd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_mark  (mark_hit[gi]),
                .i_next  (next[gi]),
                .o_page  (page[gi])
            );
        end
    endgenerate

    pvd_scan #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept && (s_axis_tuser == pvd_pkg::CMD_COMMIT)),
        .i_head      (page[0]),
        .i_eff_x     (eff_x),
        .i_eff_y     (eff_y),
        .i_eff_z     (eff_z),
        .i_out_ready (m_axis_tready),
        .o_idle      (scan_idle),
        .o_step      (scan_step),
        .o_out_valid (m_axis_tvalid),
        .o_out_event (out_ev),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_ev.kind;
    assign m_axis_tdata = {2'b00, out_ev.z, out_ev.y, out_ev.x};

endmodule
